// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL. They compile to nothing for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TLFC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TLFC_NEVER(lbl, clk, rst_n, expr, msg) \
    `TLFC_ASSERT(lbl, clk, rst_n, !(expr), msg)
`else
`define TLFC_ASSERT(lbl, clk, rst_n, prop, msg)
`define TLFC_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// ===== src/tlfc_pkg.sv =====
package tlfc_pkg;

    localparam int PALETTE_DEPTH_DEF = 65536;
    localparam int MAX_PRESCALE_DEF  = 8;
    // Upper end of the supported prescale range; run counters are sized for it.
    localparam int MAX_PRESCALE_HI   = 16;

    localparam int IDX_W      = 16;
    localparam int WORD_W     = 32;
    localparam int HALF_W     = 16;
    localparam int FMT_W      = 3;
    localparam int PS_W       = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam int RUN_W      = $clog2(MAX_PRESCALE_HI + 5);
    localparam int CW         = 20;

    localparam logic CMD_TABLE_WRITE = 1'b0;
    localparam logic CMD_TEXEL       = 1'b1;

    localparam logic [FMT_W-1:0] FMT_PAL       = 3'd0;
    localparam logic [FMT_W-1:0] FMT_PAL_ALPHA = 3'd1;
    localparam logic [FMT_W-1:0] FMT_RGB32     = 3'd2;
    localparam logic [FMT_W-1:0] FMT_ARGB32    = 3'd3;
    localparam logic [FMT_W-1:0] FMT_YUY16     = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REMAP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BORDER   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESCALE = 2'd3;

    localparam logic [7:0]        PIX_MAX      = 8'hff;
    localparam logic [WORD_W-1:0] ALPHA_OPAQUE = 32'hff00_0000;
    localparam logic [9:0]        REMAP_RED_BASE   = 10'h200;
    localparam logic [9:0]        REMAP_GREEN_BASE = 10'h100;

    localparam logic signed [CW-1:0] K_Y     = 20'sd298;
    localparam logic signed [CW-1:0] K_RCR   = 20'sd409;
    localparam logic signed [CW-1:0] K_GCB   = 20'sd100;
    localparam logic signed [CW-1:0] K_GCR   = 20'sd208;
    localparam logic signed [CW-1:0] K_BCB   = 20'sd516;
    localparam logic signed [CW-1:0] K_MID   = 20'sd128;
    localparam logic signed [CW-1:0] K_ROUND = 20'sd128;
    localparam logic signed [CW-1:0] Y_BLACK = 20'sd16;
    // Black level offset and rounding folded into one term of the luma product.
    localparam logic signed [CW-1:0] K_BIAS  = K_Y * Y_BLACK - K_ROUND;

    typedef struct packed {
        logic             yuy;
        logic             lead;
        logic [RUN_W-1:0] bend;
        logic [RUN_W-1:0] last_k;
    } t_run_plan;

    function automatic logic [7:0] clamp8(input logic signed [CW-1:0] v);
        logic [7:0] r;
        if (v[CW-1]) begin
            r = 8'd0;
        end else if (|v[CW-2:16]) begin
            r = PIX_MAX;
        end else begin
            r = v[15:8];
        end
        return r;
    endfunction

endpackage

// ===== src/tlfc_texel_if.sv =====
interface tlfc_texel_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [31:0] pixel_word;
    logic [15:0] second_word;
    logic        line_start;
    logic        line_end;
    logic [15:0] table_index;
    logic [31:0] table_value;

    modport source (
        output valid, cmd, pixel_word, second_word, line_start, line_end,
               table_index, table_value,
        input  ready
    );
    modport sink (
        input  valid, cmd, pixel_word, second_word, line_start, line_end,
               table_index, table_value,
        output ready
    );
endinterface

// ===== src/tlfc_pixel_if.sv =====
interface tlfc_pixel_if;
    logic        valid;
    logic        ready;
    logic [31:0] argb_pixel;
    logic        run_last;

    modport source (output valid, argb_pixel, run_last, input ready);
    modport sink (input valid, argb_pixel, run_last, output ready);
endinterface

// ===== src/tlfc_ram.sv =====
module tlfc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic                     i_re_b,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re_a) begin
            o_rdata_a <= mem[i_raddr_a];
        end
        if (i_re_b) begin
            o_rdata_b <= mem[i_raddr_b];
        end
    end

endmodule

// ===== src/tlfc_color.sv =====
module tlfc_color import tlfc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_load,
    input  logic              i_yuy,
    input  logic [7:0]        i_y0,
    input  logic [7:0]        i_y1,
    input  logic [7:0]        i_cb,
    input  logic [7:0]        i_cr,
    input  logic [WORD_W-1:0] i_direct,
    output logic [WORD_W-1:0] o_p0,
    output logic [WORD_W-1:0] o_p1
);

    logic signed [CW-1:0] y0s, y1s, ds, es;
    logic signed [CW-1:0] n_c0, n_c1, n_rcr, n_gcb, n_gcr, n_bcb;
    logic signed [CW-1:0] r_c0, r_c1, r_rcr, r_gcb, r_gcr, r_bcb;
    logic                 r_yuy;
    logic [WORD_W-1:0]    r_direct;
    logic signed [CW-1:0] sr0, sg0, sb0, sr1, sg1, sb1;

    assign y0s = signed'(CW'(i_y0));
    assign y1s = signed'(CW'(i_y1));
    assign ds  = signed'(CW'(i_cb)) - K_MID;
    assign es  = signed'(CW'(i_cr)) - K_MID;

    // Products are registered; the sums and clamps work from the registers.
    assign n_c0  = y0s * K_Y - K_BIAS;
    assign n_c1  = y1s * K_Y - K_BIAS;
    assign n_rcr = es * K_RCR;
    assign n_gcb = ds * K_GCB;
    assign n_gcr = es * K_GCR;
    assign n_bcb = ds * K_BCB;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_c0     <= n_c0;
            r_c1     <= n_c1;
            r_rcr    <= n_rcr;
            r_gcb    <= n_gcb;
            r_gcr    <= n_gcr;
            r_bcb    <= n_bcb;
            r_yuy    <= i_yuy;
            r_direct <= i_direct;
        end
    end

    assign sr0 = r_c0 + r_rcr;
    assign sg0 = r_c0 - r_gcb - r_gcr;
    assign sb0 = r_c0 + r_bcb;
    assign sr1 = r_c1 + r_rcr;
    assign sg1 = r_c1 - r_gcb - r_gcr;
    assign sb1 = r_c1 + r_bcb;

    assign o_p0 = r_yuy ? {PIX_MAX, clamp8(sr0), clamp8(sg0), clamp8(sb0)} : r_direct;
    assign o_p1 = r_yuy ? {PIX_MAX, clamp8(sr1), clamp8(sg1), clamp8(sb1)} : r_direct;

endmodule

// ===== src/tlfc_seq.sv =====
module tlfc_seq import tlfc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    output logic              o_load_ready,
    input  logic [WORD_W-1:0] i_p0,
    input  logic [WORD_W-1:0] i_p1,
    input  t_run_plan         i_plan,
    tlfc_pixel_if.source      o_pixel
);

    logic              r_v;
    logic [WORD_W-1:0] r_p0, r_p1;
    t_run_plan         r_plan;
    logic [RUN_W-1:0]  r_k;
    logic              r_o_v;
    logic [WORD_W-1:0] r_o_pix;
    logic              r_o_last;
    logic              out_take, emit, last, sel1;
    logic [RUN_W-1:0]  lead_k;

    assign out_take     = !r_o_v || o_pixel.ready;
    assign emit         = r_v && out_take;
    assign last         = (r_k == r_plan.last_k);
    assign o_load_ready = !r_v || (emit && last);

    // In a pair run the second pixel sits at odd positions after the leading
    // border pair, and every position past the body is the right-edge copy.
    assign lead_k = r_plan.lead ? RUN_W'(2) : RUN_W'(0);
    assign sel1   = r_plan.yuy && ((r_k >= r_plan.bend) || ((r_k >= lead_k) && r_k[0]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v   <= 1'b0;
            r_o_v <= 1'b0;
            r_k   <= '0;
        end else begin
            if (o_load_ready) begin
                r_v <= i_load;
            end
            if (out_take) begin
                r_o_v <= emit;
            end
            if (o_load_ready && i_load) begin
                r_k <= '0;
            end else if (emit) begin
                r_k <= r_k + RUN_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load_ready && i_load) begin
            r_p0   <= i_p0;
            r_p1   <= i_p1;
            r_plan <= i_plan;
        end
        if (emit) begin
            r_o_pix  <= sel1 ? r_p1 : r_p0;
            r_o_last <= last;
        end
    end

    assign o_pixel.valid      = r_o_v;
    assign o_pixel.argb_pixel = r_o_pix;
    assign o_pixel.run_last   = r_o_last;

endmodule

// ===== src/texture_line_format_converter.sv =====
// Channel   Dir  Handshake     Beat carries
// i_texel   in   valid/ready   table write or one source texel (pair in yuy16)
// o_pixel   out  valid/ready   one ARGB pixel, run_last on the final one of a run
// i_cfg_*   in   write enable  format, remap, border, prescale registers
//
// A texel item yields n pixels at one per cycle unless the output stalls,
// n = prescale plus one per border, or 2*max(1, prescale/2) plus two per
// border in yuy16; the output register sets that rate. Table writes are done
// in the issue stage. Remapped rgb32/argb32 need three table reads on the two
// read ports of the palette RAM, so they occupy the issue stage in two phases.
// The first pixel passes the read and color stages, the sequencer and its
// output register. Reset is synchronous and clears control only; the table
// is never cleared. A stalled output backs up through the pipeline stages.
`include "assert_macros.svh"
module texture_line_format_converter import tlfc_pkg::*; #(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF,
    parameter int MAX_PRESCALE  = MAX_PRESCALE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    tlfc_texel_if.sink            i_texel,
    tlfc_pixel_if.source          o_pixel
);

    localparam int AW = $clog2(PALETTE_DEPTH);
    localparam int RECIP_SHIFT = 32;
    localparam longint unsigned RECIP =
        ((64'd1 << RECIP_SHIFT) + PALETTE_DEPTH - 1) / PALETTE_DEPTH;
    localparam int RW = $clog2(RECIP + 1);
    localparam int PW = IDX_W + RW;
    localparam int QSPAN = (1 << IDX_W) / PALETTE_DEPTH;
    localparam int QW = (QSPAN < 2) ? 1 : $clog2(QSPAN + 1);

    // Configuration registers.
    logic [FMT_W-1:0] r_fmt;
    logic             r_remap, r_border;
    logic [PS_W-1:0]  r_ps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt    <= FMT_PAL;
            r_remap  <= 1'b0;
            r_border <= 1'b0;
            r_ps     <= PS_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FORMAT:   r_fmt    <= i_cfg_data[FMT_W-1:0];
                CFG_REMAP:    r_remap  <= i_cfg_data[0];
                CFG_BORDER:   r_border <= i_cfg_data[0];
                CFG_PRESCALE: r_ps     <= i_cfg_data[PS_W-1:0];
                default: ;
            endcase
        end
    end

    logic fmt_pal, fmt_rgb, fmt_yuy, fmt_ok;
    assign fmt_pal = (r_fmt == FMT_PAL) || (r_fmt == FMT_PAL_ALPHA);
    assign fmt_rgb = (r_fmt == FMT_RGB32) || (r_fmt == FMT_ARGB32);
    assign fmt_yuy = (r_fmt == FMT_YUY16);
    assign fmt_ok  = fmt_pal || fmt_rgb || fmt_yuy;

    logic [RUN_W-1:0] ps_eff, reps;
    always_comb begin
        if (r_ps == '0) begin
            ps_eff = RUN_W'(1);
        end else if (int'(r_ps) > MAX_PRESCALE) begin
            ps_eff = RUN_W'(MAX_PRESCALE);
        end else begin
            ps_eff = RUN_W'(r_ps);
        end
        reps = ps_eff >> 1;
        if (reps == '0) begin
            reps = RUN_W'(1);
        end
    end

    // Input register; the quotient of the table index by the depth is taken here.
    logic              r_p0_v, r_p0_cmd, r_p0_start, r_p0_end;
    logic [WORD_W-1:0] r_p0_word, r_p0_tval;
    logic [HALF_W-1:0] r_p0_second;
    logic [IDX_W-1:0]  r_p0_idx;
    logic [QW-1:0]     r_p0_q;
    logic              texel_acc, p0_go;
    logic [IDX_W-1:0]  idx_in;
    logic [PW-1:0]     prod;

    assign i_texel.ready = !r_p0_v || p0_go;
    assign texel_acc     = i_texel.valid && i_texel.ready;
    assign idx_in = (i_texel.cmd == CMD_TEXEL) ? i_texel.pixel_word[IDX_W-1:0]
                                               : i_texel.table_index;
    assign prod   = PW'(idx_in) * PW'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0_v <= 1'b0;
        end else if (i_texel.ready) begin
            r_p0_v <= i_texel.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (texel_acc) begin
            r_p0_cmd    <= i_texel.cmd;
            r_p0_word   <= i_texel.pixel_word;
            r_p0_second <= i_texel.second_word;
            r_p0_start  <= i_texel.line_start;
            r_p0_end    <= i_texel.line_end;
            r_p0_tval   <= i_texel.table_value;
            r_p0_idx    <= idx_in;
            r_p0_q      <= QW'(prod >> RECIP_SHIFT);
        end
    end

    // Issue stage: table write or table reads toward the read stage.
    logic             is_texel, goes_s1, need3, s1_free, first_issue, s1_load;
    logic             r_phase;
    logic [IDX_W-1:0] qd;
    logic [AW-1:0]    wrap_addr;
    logic             ram_we, ram_re_a, ram_re_b;
    logic [AW-1:0]    ram_raddr_a, ram_raddr_b;
    logic [WORD_W-1:0] rd_a, rd_b;

    assign is_texel    = (r_p0_cmd == CMD_TEXEL);
    assign goes_s1     = is_texel && fmt_ok;
    assign need3       = is_texel && fmt_rgb && r_remap;
    assign p0_go       = r_p0_v && (!goes_s1 || (s1_free && (!need3 || r_phase)));
    assign first_issue = r_p0_v && need3 && !r_phase && s1_free;
    assign s1_load     = p0_go && goes_s1;
    assign qd          = IDX_W'(r_p0_q * PALETTE_DEPTH);
    assign wrap_addr   = AW'(r_p0_idx - qd);
    assign ram_we      = p0_go && !is_texel;

    always_comb begin
        ram_re_a    = 1'b0;
        ram_re_b    = 1'b0;
        ram_raddr_a = wrap_addr;
        ram_raddr_b = '0;
        if (first_issue) begin
            ram_re_a    = 1'b1;
            ram_re_b    = 1'b1;
            ram_raddr_a = AW'(REMAP_RED_BASE) | AW'(r_p0_word[23:16]);
            ram_raddr_b = AW'(REMAP_GREEN_BASE) | AW'(r_p0_word[15:8]);
        end else if (s1_load) begin
            if (fmt_pal) begin
                ram_re_a = 1'b1;
            end else if (need3) begin
                ram_re_a    = 1'b1;
                ram_raddr_a = AW'(r_p0_word[7:0]);
            end else if (fmt_yuy && r_remap) begin
                ram_re_a    = 1'b1;
                ram_re_b    = 1'b1;
                ram_raddr_a = AW'(r_p0_word[15:8]);
                ram_raddr_b = AW'(r_p0_second[15:8]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
        end else if (first_issue) begin
            r_phase <= 1'b1;
        end else if (p0_go) begin
            r_phase <= 1'b0;
        end
    end

    tlfc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (wrap_addr),
        .i_wdata   (r_p0_tval),
        .i_re_a    (ram_re_a),
        .i_raddr_a (ram_raddr_a),
        .o_rdata_a (rd_a),
        .i_re_b    (ram_re_b),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_b (rd_b)
    );

    // Read stage: table data arrives; the red and green remap entries of a
    // three-read item are merged into the accumulator before the blue one arrives.
    logic              r_s1_v, r_s1_part, r_s1_start, r_s1_end;
    logic [WORD_W-1:0] r_s1_word, r_acc;
    logic [HALF_W-1:0] r_s1_second;
    logic              s2_free, s1_adv, s3_free;
    logic [WORD_W-1:0] direct_pix;
    logic [7:0]        y0, y1;
    logic              bs, be;
    logic [RUN_W-1:0]  body, edge_w, run_n;
    t_run_plan         n_plan;

    assign s1_free = !r_s1_v || s2_free;
    assign s1_adv  = r_s1_v && s2_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v    <= 1'b0;
            r_s1_part <= 1'b0;
        end else begin
            r_s1_part <= first_issue;
            if (s1_free) begin
                r_s1_v <= s1_load;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_word   <= r_p0_word;
            r_s1_second <= r_p0_second;
            r_s1_start  <= r_p0_start;
            r_s1_end    <= r_p0_end;
        end
        if (r_s1_part) begin
            r_acc <= rd_a | rd_b;
        end
    end

    always_comb begin
        case (r_fmt)
            FMT_PAL:       direct_pix = ALPHA_OPAQUE | rd_a;
            FMT_PAL_ALPHA: direct_pix = rd_a;
            FMT_RGB32:     direct_pix = ALPHA_OPAQUE | (r_remap ? (r_acc | rd_a) : r_s1_word);
            FMT_ARGB32:    direct_pix = r_remap ? ((r_s1_word & ALPHA_OPAQUE) | r_acc | rd_a)
                                                : r_s1_word;
            default:       direct_pix = r_s1_word;
        endcase
    end

    assign y0 = r_remap ? rd_a[7:0] : r_s1_word[15:8];
    assign y1 = r_remap ? rd_b[7:0] : r_s1_second[15:8];

    assign bs     = r_border && r_s1_start;
    assign be     = r_border && r_s1_end;
    assign body   = fmt_yuy ? (reps << 1) : ps_eff;
    assign edge_w = fmt_yuy ? RUN_W'(2) : RUN_W'(1);
    assign run_n  = body + (bs ? edge_w : '0) + (be ? edge_w : '0);

    always_comb begin
        n_plan.yuy    = fmt_yuy;
        n_plan.lead   = bs;
        n_plan.bend   = (bs ? RUN_W'(2) : RUN_W'(0)) + (reps << 1);
        n_plan.last_k = run_n - RUN_W'(1);
    end

    // Color stage.
    logic              r_s2_v;
    t_run_plan         r_s2_plan;
    logic [WORD_W-1:0] pix0, pix1;

    assign s2_free = !r_s2_v || s3_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (s2_free) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s2_plan <= n_plan;
        end
    end

    tlfc_color u_color (
        .i_clk    (i_clk),
        .i_load   (s1_adv),
        .i_yuy    (fmt_yuy),
        .i_y0     (y0),
        .i_y1     (y1),
        .i_cb     (r_s1_word[7:0]),
        .i_cr     (r_s1_second[7:0]),
        .i_direct (direct_pix),
        .o_p0     (pix0),
        .o_p1     (pix1)
    );

    tlfc_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (r_s2_v),
        .o_load_ready (s3_free),
        .i_p0         (pix0),
        .i_p1         (pix1),
        .i_plan       (r_s2_plan),
        .o_pixel      (o_pixel)
    );

    `TLFC_NEVER(a_part_alone, i_clk, i_rst_n, r_s1_part && r_s1_v, "partial remap beat overlaps a valid read stage")
    `TLFC_ASSERT(a_phase_two, i_clk, i_rst_n, r_s1_part |-> (p0_go && ram_re_a), "second remap read did not follow the first")
    `TLFC_NEVER(a_hold_no_read, i_clk, i_rst_n, r_s1_v && !s2_free && (ram_re_a || ram_re_b), "table read while read stage holds data")
    `TLFC_NEVER(a_write_no_read, i_clk, i_rst_n, ram_we && (ram_re_a || ram_re_b), "table write and read in the same cycle")

endmodule
